// ===== hdl/bts_pkg.sv =====
`default_nettype none

package bts_pkg;

   localparam int unsigned COORD_BITS_DEF     = 12;
   localparam int unsigned DEPTH_BITS_DEF     = 16;
   localparam int unsigned INTENSITY_FRAC_DEF = 8;

   localparam int unsigned CHAN_BITS     = 8;
   localparam int unsigned CSR_DATA_BITS = 64;
   localparam int unsigned CSR_ADDR_BITS = 6;

   typedef enum logic [2:0] {
      REG_POS_A   = 3'd0,
      REG_POS_B   = 3'd1,
      REG_POS_C   = 3'd2,
      REG_SHADE_A = 3'd3,
      REG_SHADE_B = 3'd4,
      REG_SHADE_C = 3'd5
   } csr_reg_type;

endpackage

`default_nettype wire

// ===== hdl/barycentric_triangle_pixel_shade.sv =====
`default_nettype none

// Channel   Ports                         Word
// -------   ---------------------------   ----------------------------------------------
// pixel in  req_tvalid/tready/tdata       pixel_x, pixel_y
// result    rsp_tvalid/tready/tdata/tuser out_x, out_y, red, green, blue, depth; covered
// setup     csr_psel/penable/pwrite/...   six vertex registers at byte address 8*i
//
// One pixel is taken every clock while no result word is held on rsp_tready.
// Reset clears the pipeline valid bits and the vertex registers.
// When a result word waits on rsp_tready the whole pipeline holds; nothing is lost.
// Triangle setup values follow a register write through the setup register chain.

module barycentric_triangle_pixel_shade
   import bts_pkg::*;
#(
   parameter int unsigned COORD_BITS          = COORD_BITS_DEF,
   parameter int unsigned DEPTH_BITS          = DEPTH_BITS_DEF,
   parameter int unsigned INTENSITY_FRAC_BITS = INTENSITY_FRAC_DEF
) (
   input  wire                                            clock,
   input  wire                                            reset,
   input  wire                                            req_tvalid,
   output logic                                           req_tready,
   // pixel_x, pixel_y
   input  wire  [((2*COORD_BITS+7)/8)*8-1:0]              req_tdata,
   output logic                                           rsp_tvalid,
   input  wire                                            rsp_tready,
   // out_x, out_y, red, green, blue, depth
   output logic [((2*COORD_BITS+3*CHAN_BITS+DEPTH_BITS+7)/8)*8-1:0] rsp_tdata,
   // covered
   output logic                                           rsp_tuser,
   input  wire                                            csr_psel,
   input  wire                                            csr_penable,
   input  wire                                            csr_pwrite,
   input  wire  [CSR_ADDR_BITS-1:0]                       csr_paddr,
   input  wire  [CSR_DATA_BITS-1:0]                       csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]                       csr_prdata,
   output logic                                           csr_pready
);

   localparam int unsigned C   = COORD_BITS;
   localparam int unsigned DB  = DEPTH_BITS;
   localparam int unsigned F   = INTENSITY_FRAC_BITS;
   localparam int unsigned CB  = CHAN_BITS;
   localparam int unsigned IB  = F + 2;
   localparam int unsigned PW  = 2*C + DB;
   localparam int unsigned SW  = 3*CB + IB;
   localparam int unsigned DW1 = C + 1;
   localparam int unsigned PB  = 2*DW1;
   localparam int unsigned NB  = 2*C + 4;
   localparam int unsigned NU  = 2*C + 1;
   localparam int unsigned SZB = NU + DB + 3;
   localparam int unsigned SIB = NU + IB + 3;
   localparam int unsigned SIU = NU + IB;
   localparam int unsigned SCB = NU + CB + 2;
   localparam int unsigned SL  = SCB / 2;
   localparam int unsigned CW  = SCB + SIU;
   localparam int unsigned ZW  = NU + DB + 2;
   localparam int unsigned ND  = (DB > 9) ? DB : 9;
   localparam int unsigned NS  = 9 + ND;
   localparam int unsigned ODW = ((2*C + 3*CB + DB + 7) / 8) * 8;

   // ---------------- configuration registers ----------------
   logic [PW-1:0] pos_ff   [3];
   logic [SW-1:0] shade_ff [3];
   logic          csr_wr;
   csr_reg_type   csr_idx;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_reg_type'(csr_paddr[5:3]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]   <= '0;
            shade_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         case (csr_idx)
            REG_POS_A:   pos_ff[0]   <= csr_pwdata[PW-1:0];
            REG_POS_B:   pos_ff[1]   <= csr_pwdata[PW-1:0];
            REG_POS_C:   pos_ff[2]   <= csr_pwdata[PW-1:0];
            REG_SHADE_A: shade_ff[0] <= csr_pwdata[SW-1:0];
            REG_SHADE_B: shade_ff[1] <= csr_pwdata[SW-1:0];
            REG_SHADE_C: shade_ff[2] <= csr_pwdata[SW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_POS_A:   csr_prdata = CSR_DATA_BITS'(pos_ff[0]);
         REG_POS_B:   csr_prdata = CSR_DATA_BITS'(pos_ff[1]);
         REG_POS_C:   csr_prdata = CSR_DATA_BITS'(pos_ff[2]);
         REG_SHADE_A: csr_prdata = CSR_DATA_BITS'(shade_ff[0]);
         REG_SHADE_B: csr_prdata = CSR_DATA_BITS'(shade_ff[1]);
         REG_SHADE_C: csr_prdata = CSR_DATA_BITS'(shade_ff[2]);
         default:     csr_prdata = '0;
      endcase
   end

   // ---------------- vertex fields ----------------
   logic signed [C-1:0]  vx  [3];
   logic signed [C-1:0]  vy  [3];
   logic signed [DB-1:0] vz  [3];
   logic signed [IB-1:0] vi  [3];
   logic [CB-1:0]        col [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vx[i] = pos_ff[i][C-1:0];
         vy[i] = pos_ff[i][2*C-1:C];
         vz[i] = pos_ff[i][PW-1:2*C];
         vi[i] = shade_ff[i][SW-1:3*CB];
         for (int k = 0; k < 3; k++) begin
            col[i][k] = shade_ff[i][k*CB +: CB];
         end
      end
   end

   // ---------------- triangle setup (follows the registers) ----------------
   logic signed [DW1-1:0] ea_ff, eb_ff, ec_ff, ed_ff;
   logic signed [PB-1:0]  dp0_ff, dp1_ff;
   logic signed [NB-1:0]  det_ff;
   logic signed [NB-1:0]  det_abs_in;
   logic [NU-1:0]         detabs_ff;
   logic                  detneg_ff;
   logic [2*NU-1:0]       det2_ff;

   assign det_abs_in = det_ff[NB-1] ? -det_ff : det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ea_ff     <= '0;
         eb_ff     <= '0;
         ec_ff     <= '0;
         ed_ff     <= '0;
         dp0_ff    <= '0;
         dp1_ff    <= '0;
         det_ff    <= '0;
         detabs_ff <= '0;
         detneg_ff <= 1'b0;
         det2_ff   <= '0;
      end else begin
         ea_ff     <= vy[1] - vy[2];
         eb_ff     <= vx[2] - vx[1];
         ec_ff     <= vy[2] - vy[0];
         ed_ff     <= vx[0] - vx[2];
         dp0_ff    <= ea_ff * ed_ff;
         dp1_ff    <= eb_ff * ec_ff;
         det_ff    <= dp0_ff - dp1_ff;
         detneg_ff <= det_ff[NB-1];
         detabs_ff <= det_abs_in[NU-1:0];
         det2_ff   <= detabs_ff * detabs_ff;
      end
   end

   // ---------------- pipeline control ----------------
   logic          ce;
   logic          rsp_valid_ff;
   logic          vld_ff [NS];
   logic [2*C-1:0] xy_ff [NS];
   logic          cov_ff [NS];
   logic          cov_in;

   assign ce         = !rsp_valid_ff || rsp_tready;
   assign req_tready = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (ce) begin
         vld_ff[0] <= req_tvalid;
         for (int s = 1; s < NS; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         xy_ff[0]  <= req_tdata[2*C-1:0];
         cov_ff[0] <= 1'b0;
         for (int s = 1; s < NS; s++) begin
            xy_ff[s]  <= xy_ff[s-1];
            cov_ff[s] <= (s == 4) ? cov_in : cov_ff[s-1];
         end
      end
   end

   // ---------------- edge functions and coverage ----------------
   logic signed [C-1:0]   px_in, py_in;
   logic signed [DW1-1:0] dx_ff, dy_ff;
   logic signed [PB-1:0]  p_ff [4];
   logic signed [NB-1:0]  n0r_ff, n1r_ff, n2r_ff;
   logic signed [NB-1:0]  s4n0_ff, s4n1_ff;
   logic signed [NB-1:0]  nn_in [3];
   logic [NU-1:0]         n_ff [3];

   assign px_in = req_tdata[C-1:0];
   assign py_in = req_tdata[2*C-1:C];

   always_comb begin
      nn_in[0] = detneg_ff ? -s4n0_ff : s4n0_ff;
      nn_in[1] = detneg_ff ? -s4n1_ff : s4n1_ff;
      nn_in[2] = detneg_ff ? -n2r_ff  : n2r_ff;
      cov_in   = (detabs_ff != '0) && !nn_in[0][NB-1] && !nn_in[1][NB-1]
                 && !nn_in[2][NB-1];
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         dx_ff   <= px_in - vx[2];
         dy_ff   <= py_in - vy[2];
         p_ff[0] <= ea_ff * dx_ff;
         p_ff[1] <= eb_ff * dy_ff;
         p_ff[2] <= ec_ff * dx_ff;
         p_ff[3] <= ed_ff * dy_ff;
         n0r_ff  <= p_ff[0] + p_ff[1];
         n1r_ff  <= p_ff[2] + p_ff[3];
         s4n0_ff <= n0r_ff;
         s4n1_ff <= n1r_ff;
         n2r_ff  <= det_ff - n0r_ff - n1r_ff;
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= nn_in[i][NU-1:0];
         end
      end
   end

   // ---------------- weighted sums ----------------
   logic signed [NU+DB:0] zp_ff [3];
   logic signed [NU+IB:0] ip_ff [3];
   logic [NU+CB-1:0]      cp_ff [3][3];
   logic signed [SZB-1:0] sz_in, sz_ff;
   logic signed [SIB-1:0] si_sum;
   logic [SIU-1:0]        si_in, si_ff;
   logic [SCB-1:0]        sc_in [3];
   logic [SCB-1:0]        sc_ff [3];

   always_comb begin
      sz_in  = zp_ff[0] + zp_ff[1] + zp_ff[2];
      si_sum = ip_ff[0] + ip_ff[1] + ip_ff[2];
      // A negative light intensity clamps to zero.
      si_in  = si_sum[SIB-1] ? '0 : si_sum[SIU-1:0];
      for (int k = 0; k < 3; k++) begin
         sc_in[k] = SCB'(cp_ff[0][k]) + SCB'(cp_ff[1][k]) + SCB'(cp_ff[2][k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            zp_ff[i] <= $signed({1'b0, n_ff[i]}) * vz[i];
            ip_ff[i] <= $signed({1'b0, n_ff[i]}) * vi[i];
            for (int k = 0; k < 3; k++) begin
               cp_ff[i][k] <= n_ff[i] * col[i][k];
            end
         end
         sz_ff <= sz_in;
         si_ff <= si_in;
         for (int k = 0; k < 3; k++) begin
            sc_ff[k] <= sc_in[k];
         end
      end
   end

   // ---------------- dividends ----------------
   logic [SL+SIU-1:0]     wlo_ff [3];
   logic [SCB-SL+SIU-1:0] whi_ff [3];
   logic [SZB-1:0]        szabs_in;
   logic [ZW-1:0]         dn_ff, dn9_ff;
   logic                  zneg_ff, zneg9_ff;
   logic [CW-1:0]         w_ff [3];

   assign szabs_in = sz_ff[SZB-1] ? -sz_ff : sz_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int k = 0; k < 3; k++) begin
            wlo_ff[k] <= sc_ff[k][SL-1:0] * si_ff;
            whi_ff[k] <= sc_ff[k][SCB-1:SL] * si_ff;
            w_ff[k]   <= (CW'(whi_ff[k]) << SL) + CW'(wlo_ff[k]);
         end
         // Rounding to nearest, ties away from zero: (2|sz| + det) / (2 det).
         dn_ff    <= {szabs_in[ZW-2:0], 1'b0} + ZW'(detabs_ff);
         zneg_ff  <= sz_ff[SZB-1];
         dn9_ff   <= dn_ff;
         zneg9_ff <= zneg_ff;
      end
   end

   // ---------------- restoring dividers, one quotient bit per stage ----------------
   logic [ZW-1:0] zr_ff [ND];
   logic [DB-1:0] zq_ff [ND];
   logic          zs_ff [ND];
   logic [CW-1:0] cr_ff [ND][3];
   logic [CB-1:0] cq_ff [ND][3];
   logic          cs_ff [ND][3];

   logic [ZW-1:0] dd;
   logic [CW-1:0] dc;

   assign dd = ZW'({detabs_ff, 1'b0});
   assign dc = CW'(det2_ff) << F;

   for (genvar j = 0; j < ND; j++) begin : g_div
      logic [ZW-1:0] zr_src, zr_in;
      logic [DB-1:0] zq_src, zq_in;
      logic          zs_src;
      logic [CW-1:0] cr_src [3];
      logic [CW-1:0] cr_in  [3];
      logic [CB-1:0] cq_src [3];
      logic [CB-1:0] cq_in  [3];
      logic          cs_src [3];
      logic          cs_in  [3];

      if (j == 0) begin : g_first
         always_comb begin
            zr_src = dn9_ff;
            zq_src = '0;
            zs_src = zneg9_ff;
            for (int k = 0; k < 3; k++) begin
               cr_src[k] = w_ff[k];
               cq_src[k] = '0;
               cs_src[k] = 1'b0;
            end
         end
      end else begin : g_next
         always_comb begin
            zr_src = zr_ff[j-1];
            zq_src = zq_ff[j-1];
            zs_src = zs_ff[j-1];
            for (int k = 0; k < 3; k++) begin
               cr_src[k] = cr_ff[j-1][k];
               cq_src[k] = cq_ff[j-1][k];
               cs_src[k] = cs_ff[j-1][k];
            end
         end
      end

      if (j < DB) begin : g_zbit
         always_comb begin
            zr_in = zr_src;
            zq_in = zq_src;
            if (zr_src >= (dd << (DB-1-j))) begin
               zr_in            = zr_src - (dd << (DB-1-j));
               zq_in[DB-1-j]    = 1'b1;
            end
         end
      end else begin : g_zpass
         assign zr_in = zr_src;
         assign zq_in = zq_src;
      end

      if (j == 0) begin : g_csat
         // Quotients of 256 and more saturate the channel.
         always_comb begin
            for (int k = 0; k < 3; k++) begin
               cr_in[k] = cr_src[k];
               cq_in[k] = cq_src[k];
               cs_in[k] = cs_src[k] | (cr_src[k] >= (dc << CB));
            end
         end
      end else if (j <= CB) begin : g_cbit
         always_comb begin
            for (int k = 0; k < 3; k++) begin
               cr_in[k] = cr_src[k];
               cq_in[k] = cq_src[k];
               cs_in[k] = cs_src[k];
               if (cr_src[k] >= (dc << (CB-j))) begin
                  cr_in[k]        = cr_src[k] - (dc << (CB-j));
                  cq_in[k][CB-j]  = 1'b1;
               end
            end
         end
      end else begin : g_cpass
         always_comb begin
            for (int k = 0; k < 3; k++) begin
               cr_in[k] = cr_src[k];
               cq_in[k] = cq_src[k];
               cs_in[k] = cs_src[k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            zr_ff[j] <= zr_in;
            zq_ff[j] <= zq_in;
            zs_ff[j] <= zs_src;
            for (int k = 0; k < 3; k++) begin
               cr_ff[j][k] <= cr_in[k];
               cq_ff[j][k] <= cq_in[k];
               cs_ff[j][k] <= cs_in[k];
            end
         end
      end
   end

   // ---------------- result word ----------------
   logic [CB-1:0] chan_in [3];
   logic [DB-1:0] depth_in;
   logic [DB-1:0] zq_last;
   logic          cov_last;
   logic [ODW-1:0] rsp_tdata_ff;
   logic           rsp_tuser_ff;

   assign zq_last  = zq_ff[ND-1];
   assign cov_last = cov_ff[NS-1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         chan_in[k] = !cov_last ? '0 : (cs_ff[ND-1][k] ? {CB{1'b1}} : cq_ff[ND-1][k]);
      end
      if (!cov_last) begin
         depth_in = '0;
      end else if (zs_ff[ND-1]) begin
         depth_in = -zq_last;
      end else if (zq_last[DB-1]) begin
         depth_in = {1'b0, {(DB-1){1'b1}}};
      end else begin
         depth_in = zq_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         rsp_valid_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rsp_tdata_ff <= ODW'({depth_in, chan_in[2], chan_in[1], chan_in[0], xy_ff[NS-1]});
         rsp_tuser_ff <= cov_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// ===== tb/tri_shade_checker.sv =====
`default_nettype none

module tri_shade_checker
   import bts_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [23:0] req_tdata,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [63:0] rsp_tdata,
   input  wire         rsp_tuser,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [5:0]  csr_paddr,
   input  wire  [63:0] csr_pwdata,
   input  wire         csr_pready,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        covered;
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] depth;
   } shaded_pixel_type;

   logic [39:0] vert_pos[3];
   logic [33:0] vert_shade[3];
   shaded_pixel_type pending_pixels[$];
   int mismatches = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // min(255, floor(sc * si / (det * det * 2^8)))
   function automatic logic [7:0] scale_channel(longint sc, longint si, longint det);
      logic [127:0] prod, den, q;
      prod = 128'(sc) * 128'(si);
      den  = 128'(det) * 128'(det) << INTENSITY_FRAC_DEF;
      q    = prod / den;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic shaded_pixel_type shade_pixel(logic [11:0] px_bits,
                                                    logic [11:0] py_bits);
      shaded_pixel_type r;
      longint vx[3], vy[3], vz[3], vi[3], n[3];
      longint px, py, det, si, sz, sc, z;
      px = $signed(px_bits);
      py = $signed(py_bits);
      for (int i = 0; i < 3; i++) begin
         vx[i] = $signed(vert_pos[i][11:0]);
         vy[i] = $signed(vert_pos[i][23:12]);
         vz[i] = $signed(vert_pos[i][39:24]);
         vi[i] = $signed(vert_shade[i][33:24]);
      end
      det  = (vy[1] - vy[2]) * (vx[0] - vx[2]) + (vx[2] - vx[1]) * (vy[0] - vy[2]);
      n[0] = (vy[1] - vy[2]) * (px - vx[2]) + (vx[2] - vx[1]) * (py - vy[2]);
      n[1] = (vy[2] - vy[0]) * (px - vx[2]) + (vx[0] - vx[2]) * (py - vy[2]);
      if (det < 0) begin
         det  = -det;
         n[0] = -n[0];
         n[1] = -n[1];
      end
      n[2] = det - n[0] - n[1];
      r = '0;
      r.x = px_bits;
      r.y = py_bits;
      r.covered = det != 0 && n[0] >= 0 && n[1] >= 0 && n[2] >= 0;
      if (!r.covered)
         return r;
      si = n[0] * vi[0] + n[1] * vi[1] + n[2] * vi[2];
      sz = n[0] * vz[0] + n[1] * vz[1] + n[2] * vz[2];
      if (si < 0)
         si = 0;
      sc = n[0] * vert_shade[0][7:0] + n[1] * vert_shade[1][7:0] + n[2] * vert_shade[2][7:0];
      r.red = scale_channel(sc, si, det);
      sc = n[0] * vert_shade[0][15:8] + n[1] * vert_shade[1][15:8]
         + n[2] * vert_shade[2][15:8];
      r.green = scale_channel(sc, si, det);
      sc = n[0] * vert_shade[0][23:16] + n[1] * vert_shade[1][23:16]
         + n[2] * vert_shade[2][23:16];
      r.blue = scale_channel(sc, si, det);
      // Round half away from zero, then saturate to the depth range.
      if (sz >= 0)
         z = (2 * sz + det) / (2 * det);
      else
         z = -((-2 * sz + det) / (2 * det));
      if (z > 32767)
         z = 32767;
      if (z < -32768)
         z = -32768;
      r.depth = z[15:0];
      return r;
   endfunction

   always @(posedge clock) begin
      shaded_pixel_type want;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vert_pos[i]   <= '0;
            vert_shade[i] <= '0;
         end
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_reg_type'(csr_paddr[5:3]))
               REG_POS_A:   vert_pos[0]   <= csr_pwdata[39:0];
               REG_POS_B:   vert_pos[1]   <= csr_pwdata[39:0];
               REG_POS_C:   vert_pos[2]   <= csr_pwdata[39:0];
               REG_SHADE_A: vert_shade[0] <= csr_pwdata[33:0];
               REG_SHADE_B: vert_shade[1] <= csr_pwdata[33:0];
               REG_SHADE_C: vert_shade[2] <= csr_pwdata[33:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pending_pixels.push_back(shade_pixel(req_tdata[11:0], req_tdata[23:12]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[23:0], 0);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_tuser !== want.covered)
                  report_mismatch("covered", rsp_tuser, want.covered);
               if (rsp_tdata[11:0] !== want.x)
                  report_mismatch("x", rsp_tdata[11:0], want.x);
               if (rsp_tdata[23:12] !== want.y)
                  report_mismatch("y", rsp_tdata[23:12], want.y);
               if (rsp_tdata[31:24] !== want.red)
                  report_mismatch("red", rsp_tdata[31:24], want.red);
               if (rsp_tdata[39:32] !== want.green)
                  report_mismatch("green", rsp_tdata[39:32], want.green);
               if (rsp_tdata[47:40] !== want.blue)
                  report_mismatch("blue", rsp_tdata[47:40], want.blue);
               if (rsp_tdata[63:48] !== want.depth)
                  report_mismatch("depth", $signed(rsp_tdata[63:48]), $signed(want.depth));
            end
         end
      end
      fail_count <= mismatches + pending_pixels.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb
   import bts_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [23:0] req_tdata = '0;     // pixel_x, pixel_y
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [63:0] rsp_tdata;          // out_x, out_y, red, green, blue, depth
   wire         rsp_tuser;          // covered
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   wire  [63:0] csr_prdata;
   wire         csr_pready;
   int          fail_count;

   int  pixels_sent = 0;
   int  pixels_shaded = 0;
   int  cycles = 0;
   bit  no_idle = 0;
   bit  backlog_done = 0;
   int  sink_stall = 0;
   int  tri_x[3], tri_y[3];

   barycentric_triangle_pixel_shade dut (.*);

   tri_shade_checker checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .rsp_tvalid, .rsp_tready,
      .rsp_tdata, .rsp_tuser, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_pready, .fail_count
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         pixels_shaded <= pixels_shaded + 1;
   end

   // Result sink: random short stalls, rare long ones, and one long backlog
   // while the source keeps offering pixels.
   always @(posedge clock) begin
      if (!backlog_done && pixels_sent >= 500) begin
         backlog_done <= 1;
         sink_stall = 300;
      end
      if (sink_stall > 0) begin
         sink_stall--;
         rsp_tready <= 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 75) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         sink_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(0, 2);
      end
   end

   task automatic csr_write(input csr_reg_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [63:0] pack_pos(int x, int y, int z);
      return {24'h0, z[15:0], y[11:0], x[11:0]};
   endfunction

   function automatic logic [63:0] pack_shade(int r, int g, int b, int inten);
      return {30'h0, inten[9:0], b[7:0], g[7:0], r[7:0]};
   endfunction

   // Stops offering pixels, waits until every expected word is back, then
   // lets the pipeline drain.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pixels_shaded != pixels_sent)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic load_triangle(input int x[3], input int y[3], input int z[3],
                                input logic [63:0] shade[3]);
      wait_drained();
      csr_write(REG_POS_A, pack_pos(x[0], y[0], z[0]));
      csr_write(REG_POS_B, pack_pos(x[1], y[1], z[1]));
      csr_write(REG_POS_C, pack_pos(x[2], y[2], z[2]));
      csr_write(REG_SHADE_A, shade[0]);
      csr_write(REG_SHADE_B, shade[1]);
      csr_write(REG_SHADE_C, shade[2]);
      tri_x = x;
      tri_y = y;
      // Let the triangle setup settle before pixels arrive.
      repeat (6) @(posedge clock);
   endtask

   task automatic send_pixel(input int x, input int y);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {y[11:0], x[11:0]};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pixels_sent++;
      if (no_idle)
         gap = 0;
      else if ($urandom_range(0, 99) < 60)
         gap = 0;
      else if ($urandom_range(0, 9) < 8)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(5, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int clip12(int v);
      return (v > 2047) ? 2047 : (v < -2048) ? -2048 : v;
   endfunction

   task automatic random_triangle();
      int x[3], y[3], z[3], cx, cy, span, inten;
      logic [63:0] shade[3];
      span = ($urandom_range(0, 9) < 3) ? 2048 : $urandom_range(3, 60);
      cx = $signed(12'($urandom));
      cy = $signed(12'($urandom));
      for (int i = 0; i < 3; i++) begin
         if (span == 2048) begin
            x[i] = $signed(12'($urandom));
            y[i] = $signed(12'($urandom));
         end else begin
            x[i] = clip12(cx - span + $urandom_range(0, 2 * span));
            y[i] = clip12(cy - span + $urandom_range(0, 2 * span));
         end
         z[i] = $signed(16'($urandom));
         inten = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 511) : $urandom;
         shade[i] = pack_shade($urandom, $urandom, $urandom, inten);
         // Junk above the register width must be dropped.
         if ($urandom_range(0, 3) == 0)
            shade[i][63:34] = 30'($urandom);
      end
      load_triangle(x, y, z, shade);
   endtask

   task automatic random_pixel();
      int lx, hx, ly, hy;
      if ($urandom_range(0, 9) < 2) begin
         send_pixel($signed(12'($urandom)), $signed(12'($urandom)));
      end else begin
         lx = tri_x[0]; hx = tri_x[0]; ly = tri_y[0]; hy = tri_y[0];
         for (int i = 1; i < 3; i++) begin
            if (tri_x[i] < lx) lx = tri_x[i];
            if (tri_x[i] > hx) hx = tri_x[i];
            if (tri_y[i] < ly) ly = tri_y[i];
            if (tri_y[i] > hy) hy = tri_y[i];
         end
         send_pixel(lx + $urandom_range(0, hx - lx), ly + $urandom_range(0, hy - ly));
      end
   endtask

   initial begin
      int x[3], y[3], z[3];
      logic [63:0] shade[3];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Pixels against the reset triangle, which is degenerate.
      send_pixel(0, 0);
      send_pixel(-2048, 2047);

      // Right triangle with one pure channel per vertex.
      x = '{0, 100, 0}; y = '{0, 0, 100}; z = '{100, -200, 32767};
      shade = '{pack_shade(255, 0, 0, 256), pack_shade(0, 255, 0, 511),
                pack_shade(0, 0, 255, 0)};
      load_triangle(x, y, z, shade);
      send_pixel(0, 0);
      send_pixel(100, 0);
      send_pixel(0, 100);
      send_pixel(50, 0);
      send_pixel(50, 50);
      send_pixel(33, 33);
      send_pixel(101, 0);
      send_pixel(-1, 50);
      send_pixel(-2048, -2048);
      send_pixel(2047, 2047);

      // Same triangle wound the other way.
      x = '{0, 0, 100}; y = '{0, 100, 0}; z = '{100, 32767, -200};
      load_triangle(x, y, z, shade);
      send_pixel(20, 20);
      send_pixel(60, 41);

      // Collinear vertices give a zero determinant.
      x = '{0, 10, 20}; y = '{0, 10, 20}; z = '{0, 0, 0};
      load_triangle(x, y, z, shade);
      send_pixel(10, 10);
      send_pixel(5, 5);

      // Full coordinate range, extreme depths, negative intensity everywhere.
      x = '{-2048, 2047, -2048}; y = '{-2048, -2048, 2047}; z = '{-32768, 32767, 0};
      shade = '{pack_shade(255, 255, 255, -512), pack_shade(255, 255, 255, -1),
                pack_shade(255, 255, 255, -512)};
      load_triangle(x, y, z, shade);
      send_pixel(-2048, -2048);
      send_pixel(0, 0);

      // Brightest intensity at every vertex; bright channels saturate, dim ones do not.
      shade = '{pack_shade(255, 255, 255, 511), pack_shade(255, 128, 1, 511),
                pack_shade(255, 255, 255, 511)};
      load_triangle(x, y, z, shade);
      send_pixel(2047, -2048);
      send_pixel(-1000, -1000);
      send_pixel(2047, 2047);

      // An address past the last register must change nothing.
      wait_drained();
      csr_write(csr_reg_type'(3'd6), '1);
      csr_write(csr_reg_type'(3'd7), '1);
      repeat (6) @(posedge clock);
      send_pixel(-500, -500);

      for (int phase = 0; phase < 9; phase++) begin
         random_triangle();
         no_idle = (phase % 4) == 2;
         for (int k = 0; k < 125; k++)
            random_pixel();
         no_idle = 0;
      end

      wait_drained();
      repeat (2) @(posedge clock);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
